[rtl/ust_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ust_pkg
// Shared types and constants of the identifier set table.
// ----------------------------------------------------------------------------
package ust_pkg;

	localparam int CAPACITY = 256;
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int COUNT_W  = $clog2(CAPACITY + 1);
	localparam int CFG_W    = 9;
	localparam int ENTRY_W  = 9;
	localparam int UID_W    = 32;

	localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = CFG_W'(250);

	typedef enum logic [1:0] {
		OP_CHECK  = 2'd0,
		OP_SAVE   = 2'd1,
		OP_DELETE = 2'd2,
		OP_WIPE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_PRESENT = 2'd2,
		ST_ABSENT  = 2'd3
	} status_t;

	typedef struct packed {
		op_t              op;
		logic [UID_W-1:0] uid;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic               found;
		logic [ENTRY_W-1:0] entry_count;
	} rsp_t;

endpackage
`default_nettype wire

[rtl/ust_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ust_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ust_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[rtl/uid_set_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uid_set_table
// Set of distinct 32-bit identifiers kept densely in a slot RAM.
//
// A request item carries an op (check, save, delete, wipe) and a uid. It is
// taken when req_valid is high and req_stall is low; req_stall is high while
// an item is in progress, so the table works on one item at a time. Each
// request yields exactly one response item (status, found, entry_count) on
// the rsp channel, held in an output register until rsp_stall is low.
//
// The slots are searched in order through the one read port of the RAM, one
// slot per cycle. An item is handled in steps: the item is taken, the slots
// are compared in order, a miss or move step follows where needed, and the
// response is loaded. A wipe goes from taking the item straight to loading
// the response.
//
// A pending response does not block the next request: the new item is taken
// and searched, and only the final response load waits for the output
// register to drain. Reset clears the count and sets max_entries to 250; the
// slot contents need no clearing, since only occupied slots are ever compared.
// cfg_we writes max_entries; the user is to use it only while the table is idle, as the block does not enforce this.
// ----------------------------------------------------------------------------
module uid_set_table (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       req_valid,
	output logic                            req_stall,
	input  wire ust_pkg::req_t              req,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output ust_pkg::rsp_t                   rsp,
	input  wire logic                       cfg_we,
	input  wire logic [ust_pkg::CFG_W-1:0]  cfg_wdata
);

	import ust_pkg::*;

	localparam int CMP_W = (COUNT_W > CFG_W) ? COUNT_W : CFG_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_MISS,
		S_MOVE,
		S_RESP
	} state_t;

	state_t             state_q;
	op_t                op_q;
	logic [UID_W-1:0]   uid_q;
	logic [COUNT_W-1:0] count_q;
	logic [ADDR_W-1:0]  idx_q;
	status_t            status_q;
	logic               found_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;
	logic [CFG_W-1:0]   max_entries_q;

	logic               accept;
	logic [ADDR_W-1:0]  last_idx;
	logic               match;
	logic               is_full;
	logic               out_free;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [UID_W-1:0]   ram_wdata;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [UID_W-1:0]   ram_rdata;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// Index of the last occupied slot; only meaningful while the count is nonzero.
	assign last_idx = ADDR_W'(count_q - COUNT_W'(1));
	assign match    = (ram_rdata == uid_q);

	// Save is refused once the count reaches min(max_entries, CAPACITY).
	assign is_full = (CMP_W'(count_q) >= CMP_W'(max_entries_q)) ||
	                 (CMP_W'(count_q) >= CMP_W'(CAPACITY));

	// The read address feeds the slot that is compared in the next cycle.
	always_comb begin
		ram_raddr = '0;
		if (state_q == S_SCAN) begin
			if (match && op_q == OP_DELETE && idx_q != last_idx) begin
				ram_raddr = last_idx;
			end else begin
				ram_raddr = idx_q + ADDR_W'(1);
			end
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[ADDR_W-1:0];
		ram_wdata = uid_q;
		if (state_q == S_MISS && op_q == OP_SAVE && !is_full) begin
			ram_we = 1'b1;
		end else if (state_q == S_MOVE) begin
			ram_we    = 1'b1;
			ram_waddr = idx_q;
			ram_wdata = ram_rdata;
		end
	end

	ust_ram #(
		.WIDTH (UID_W),
		.DEPTH (CAPACITY)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RESET;
		end else if (cfg_we) begin
			max_entries_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			op_q        <= OP_CHECK;
			uid_q       <= '0;
			idx_q       <= '0;
			status_q    <= ST_DONE;
			found_q     <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// A new response load wins over draining the one that leaves.
			if (state_q == S_RESP && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q  <= req.op;
						uid_q <= req.uid;
						idx_q <= '0;
						if (req.op == OP_WIPE) begin
							count_q  <= '0;
							status_q <= ST_DONE;
							found_q  <= 1'b0;
							state_q  <= S_RESP;
						end else if (count_q == '0) begin
							state_q <= S_MISS;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (match) begin
						found_q <= 1'b1;
						unique case (op_q)
							OP_SAVE: begin
								status_q <= ST_PRESENT;
								state_q  <= S_RESP;
							end
							OP_DELETE: begin
								status_q <= ST_DONE;
								if (idx_q != last_idx) begin
									// Last entry is being read; it fills the hole next cycle.
									state_q <= S_MOVE;
								end else begin
									count_q <= count_q - COUNT_W'(1);
									state_q <= S_RESP;
								end
							end
							default: begin
								status_q <= ST_DONE;
								state_q  <= S_RESP;
							end
						endcase
					end else if (idx_q == last_idx) begin
						state_q <= S_MISS;
					end else begin
						idx_q <= idx_q + ADDR_W'(1);
					end
				end
				S_MISS: begin
					found_q <= 1'b0;
					state_q <= S_RESP;
					if (op_q == OP_SAVE) begin
						if (is_full) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_DONE;
							count_q  <= count_q + COUNT_W'(1);
						end
					end else begin
						status_q <= ST_ABSENT;
					end
				end
				S_MOVE: begin
					count_q <= count_q - COUNT_W'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						rsp_q.status      <= status_q;
						rsp_q.found       <= found_q;
						rsp_q.entry_count <= ENTRY_W'(count_q);
						state_q           <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The count never passes the slot capacity.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CMP_W'(CAPACITY))
		else $error("entry count above capacity");

	// Every slot write lands inside the occupied region or just past its end.
	a_write_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (CMP_W'(ram_waddr) <= CMP_W'(count_q)))
		else $error("slot write outside the table");

	// A new response is only loaded from the response state.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_RESP))
		else $error("response raised outside the response state");

	// A wipe empties the table at once.
	a_wipe_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.op == OP_WIPE) |=> (count_q == '0))
		else $error("wipe did not clear the count");

endmodule
`default_nettype wire
